@@ design/gld_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_pkg
// shared types and constants of the gif lzw decoder
// ----------------------------------------------------------------------------
package gld_pkg;

  localparam int unsigned TableDepth  = 4096;
  localparam int unsigned MaxCodeBits = 12;
  localparam int unsigned AddrW       = 12;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_PUSH  = 2'd1,
    OP_PULL  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_PIXEL  = 3'd0,
    ST_ACCEPT = 3'd1,
    ST_NEED   = 3'd2,
    ST_DONE   = 3'd3,
    ST_ERROR  = 3'd4,
    ST_DROP   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FIN_RUN  = 2'd0,
    FIN_DONE = 2'd1,
    FIN_ERR  = 2'd2
  } fin_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_WALK,
    S_WALK_D,
    S_POP_RD,
    S_POP,
    S_EMIT
  } back_state_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [3:0]  min_code_size;
    logic [31:0] pixel_count;
  } cfg_t;

endpackage

@@ design/gld_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_if
// input and output channels of the gif lzw decoder
// ----------------------------------------------------------------------------
interface gld_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;
  modport source (output valid, func, data_byte, input ready);
  modport sink   (input valid, func, data_byte, output ready);
endinterface

interface gld_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] pixel_index;
  logic       last_pixel;
  modport source (output valid, status, pixel_index, last_pixel, input ready);
  modport sink   (input valid, status, pixel_index, last_pixel, output ready);
endinterface

@@ design/gld_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_front
// accepts input beats, decodes the function code and queues them (2 deep)
// ----------------------------------------------------------------------------
module gld_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  input  logic [7:0]          data_byte_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output gld_pkg::item_t      q_item_o
);

  gld_pkg::item_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push, pop;
  gld_pkg::item_t item;

  always_comb begin
    unique case (func_i)
      gld_pkg::OP_BEGIN: item.op = gld_pkg::OP_BEGIN;
      gld_pkg::OP_PUSH:  item.op = gld_pkg::OP_PUSH;
      gld_pkg::OP_PULL:  item.op = gld_pkg::OP_PULL;
      default:           item.op = gld_pkg::OP_NONE;
    endcase
    item.data = data_byte_i;
  end

  assign in_ready_o = (count_q != 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

@@ design/gld_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_back
// lzw engine: deframing, code unpacking, chain walk, stack pops, result register
// ----------------------------------------------------------------------------
module gld_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gld_pkg::cfg_t  cfg_i,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  gld_pkg::item_t q_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [2:0]     status_o,
  output logic [7:0]     pixel_index_o,
  output logic           last_pixel_o
);

  localparam int unsigned AW = gld_pkg::AddrW;

  gld_pkg::back_state_e state_q, state_d;
  gld_pkg::fin_e        fin_q, fin_d;

  logic [12:0] depth_q, depth_d;
  logic [31:0] bitbuf_q, bitbuf_d;
  logic [5:0]  bitcnt_q, bitcnt_d;
  logic [7:0]  blk_q, blk_d;
  logic [3:0]  cw_q, cw_d;
  logic [12:0] nfc_q, nfc_d;
  logic [11:0] prev_q, prev_d;
  logic        prev_valid_q, prev_valid_d;
  logic [7:0]  first_q, first_d;
  logic [31:0] pix_q, pix_d;
  logic [11:0] cur_q, cur_d;
  logic [11:0] incode_q, incode_d;

  gld_pkg::status_e res_st_q, res_st_d;
  logic [7:0]       res_px_q, res_px_d;
  logic             res_last_q, res_last_d;

  logic             ov_q, ov_d;
  gld_pkg::status_e o_st_q, o_st_d;
  logic [7:0]       o_px_q, o_px_d;
  logic             o_last_q, o_last_d;

  logic [7:0]    stack_mem [gld_pkg::TableDepth];
  logic [11:0]   prefix_mem [gld_pkg::TableDepth];
  logic [7:0]    suffix_mem [gld_pkg::TableDepth];
  logic [7:0]    stack_rd_q;
  logic [11:0]   prefix_rd_q;
  logic [7:0]    suffix_rd_q;

  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [7:0]    st_wdata;
  logic          tb_we;
  logic [AW-1:0] tb_waddr, tb_raddr;
  logic [11:0]   tb_wprefix;
  logic [7:0]    tb_wsuffix;

  logic [3:0]  eff_mcs;
  logic [11:0] clear_code;
  logic [11:0] code;
  logic [11:0] mask;
  logic [31:0] pix_inc;

  always_comb begin
    if (cfg_i.min_code_size < 4'd2) begin
      eff_mcs = 4'd2;
    end else if (cfg_i.min_code_size > 4'd11) begin
      eff_mcs = 4'd11;
    end else begin
      eff_mcs = cfg_i.min_code_size;
    end
  end

  assign clear_code = 12'd1 << eff_mcs;
  assign mask       = 12'((13'd1 << cw_q) - 13'd1);
  assign code       = bitbuf_q[11:0] & mask;
  assign pix_inc    = pix_q + 32'd1;

  assign q_ready_o     = (state_q == gld_pkg::S_IDLE);
  assign out_valid_o   = ov_q;
  assign status_o      = o_st_q;
  assign pixel_index_o = o_px_q;
  assign last_pixel_o  = o_last_q;

  always_comb begin
    state_d      = state_q;
    fin_d        = fin_q;
    depth_d      = depth_q;
    bitbuf_d     = bitbuf_q;
    bitcnt_d     = bitcnt_q;
    blk_d        = blk_q;
    cw_d         = cw_q;
    nfc_d        = nfc_q;
    prev_d       = prev_q;
    prev_valid_d = prev_valid_q;
    first_d      = first_q;
    pix_d        = pix_q;
    cur_d        = cur_q;
    incode_d     = incode_q;
    res_st_d     = res_st_q;
    res_px_d     = res_px_q;
    res_last_d   = res_last_q;
    ov_d         = ov_q && !out_ready_i;
    o_st_d       = o_st_q;
    o_px_d       = o_px_q;
    o_last_d     = o_last_q;
    st_we        = 1'b0;
    st_waddr     = depth_q[AW-1:0];
    st_wdata     = first_q;
    st_raddr     = AW'(depth_q - 13'd1);
    tb_we        = 1'b0;
    tb_waddr     = nfc_q[AW-1:0];
    tb_raddr     = cur_q;
    tb_wprefix   = prev_q;
    tb_wsuffix   = cur_q[7:0];

    unique case (state_q)
      gld_pkg::S_IDLE: begin
        if (q_valid_i) begin
          res_px_d   = 8'd0;
          res_last_d = 1'b0;
          state_d    = gld_pkg::S_EMIT;
          unique case (q_item_i.op)
            gld_pkg::OP_BEGIN: begin
              depth_d      = 13'd0;
              bitbuf_d     = 32'd0;
              bitcnt_d     = 6'd0;
              blk_d        = 8'd0;
              cw_d         = eff_mcs + 4'd1;
              nfc_d        = {1'b0, clear_code} + 13'd2;
              prev_valid_d = 1'b0;
              prev_d       = 12'd0;
              first_d      = 8'd0;
              pix_d        = 32'd0;
              if (cfg_i.min_code_size < 4'd2 || cfg_i.min_code_size > 4'd11) begin
                fin_d    = gld_pkg::FIN_ERR;
                res_st_d = gld_pkg::ST_ERROR;
              end else begin
                fin_d    = gld_pkg::FIN_RUN;
                res_st_d = gld_pkg::ST_ACCEPT;
              end
            end
            gld_pkg::OP_PUSH: begin
              res_st_d = gld_pkg::ST_ACCEPT;
              if (blk_q == 8'd0 && q_item_i.data != 8'd0) begin
                blk_d = q_item_i.data;
              end else if (bitcnt_q > 6'd24) begin
                res_st_d = gld_pkg::ST_DROP;
              end else if (blk_q == 8'd0) begin
                bitcnt_d = bitcnt_q + 6'd8;
              end else begin
                bitbuf_d = bitbuf_q | ({24'd0, q_item_i.data} << bitcnt_q[4:0]);
                bitcnt_d = bitcnt_q + 6'd8;
                blk_d    = blk_q - 8'd1;
              end
            end
            gld_pkg::OP_PULL: begin
              if (fin_q == gld_pkg::FIN_ERR) begin
                res_st_d = gld_pkg::ST_ERROR;
              end else if (fin_q == gld_pkg::FIN_DONE) begin
                res_st_d = gld_pkg::ST_DONE;
              end else if (pix_q >= cfg_i.pixel_count) begin
                fin_d    = gld_pkg::FIN_DONE;
                res_st_d = gld_pkg::ST_DONE;
              end else if (depth_q != 13'd0) begin
                state_d = gld_pkg::S_POP_RD;
              end else begin
                state_d = gld_pkg::S_FETCH;
              end
            end
            default: begin
              res_st_d = gld_pkg::ST_NEED;
            end
          endcase
        end
      end

      gld_pkg::S_FETCH: begin
        if (bitcnt_q < {2'd0, cw_q}) begin
          res_st_d = gld_pkg::ST_NEED;
          state_d  = gld_pkg::S_EMIT;
        end else begin
          bitbuf_d = bitbuf_q >> cw_q;
          bitcnt_d = bitcnt_q - {2'd0, cw_q};
          incode_d = code;
          cur_d    = code;
          if (code == clear_code + 12'd1) begin
            fin_d    = gld_pkg::FIN_DONE;
            res_st_d = gld_pkg::ST_DONE;
            state_d  = gld_pkg::S_EMIT;
          end else if (code == clear_code) begin
            cw_d         = eff_mcs + 4'd1;
            nfc_d        = {1'b0, clear_code} + 13'd2;
            prev_valid_d = 1'b0;
          end else if ({1'b0, code} >= nfc_q) begin
            if ({1'b0, code} > nfc_q || !prev_valid_q) begin
              fin_d    = gld_pkg::FIN_ERR;
              res_st_d = gld_pkg::ST_ERROR;
              state_d  = gld_pkg::S_EMIT;
            end else begin
              st_we    = 1'b1;
              st_wdata = first_q;
              depth_d  = depth_q + 13'd1;
              cur_d    = prev_q;
              state_d  = gld_pkg::S_WALK;
            end
          end else begin
            state_d = gld_pkg::S_WALK;
          end
        end
      end

      gld_pkg::S_WALK: begin
        if (cur_q >= clear_code && depth_q < 13'(gld_pkg::TableDepth)) begin
          state_d = gld_pkg::S_WALK_D;
        end else begin
          first_d  = cur_q[7:0];
          st_wdata = cur_q[7:0];
          if (depth_q < 13'(gld_pkg::TableDepth)) begin
            st_we   = 1'b1;
            depth_d = depth_q + 13'd1;
          end
          if (prev_valid_q && nfc_q < 13'(gld_pkg::TableDepth)) begin
            tb_we = 1'b1;
            nfc_d = nfc_q + 13'd1;
            if ((nfc_q + 13'd1) >= (13'd1 << cw_q) && cw_q < 4'(gld_pkg::MaxCodeBits)) begin
              cw_d = cw_q + 4'd1;
            end
          end
          prev_d       = incode_q;
          prev_valid_d = 1'b1;
          state_d      = gld_pkg::S_POP_RD;
        end
      end

      gld_pkg::S_WALK_D: begin
        st_we    = 1'b1;
        st_wdata = suffix_rd_q;
        depth_d  = depth_q + 13'd1;
        cur_d    = prefix_rd_q;
        state_d  = gld_pkg::S_WALK;
      end

      gld_pkg::S_POP_RD: begin
        depth_d = depth_q - 13'd1;
        state_d = gld_pkg::S_POP;
      end

      gld_pkg::S_POP: begin
        pix_d      = pix_inc;
        res_st_d   = gld_pkg::ST_PIXEL;
        res_px_d   = stack_rd_q;
        res_last_d = (pix_inc == cfg_i.pixel_count);
        if (pix_inc == cfg_i.pixel_count) begin
          fin_d = gld_pkg::FIN_DONE;
        end
        state_d = gld_pkg::S_EMIT;
      end

      gld_pkg::S_EMIT: begin
        if (!ov_q || out_ready_i) begin
          ov_d     = 1'b1;
          o_st_d   = res_st_q;
          o_px_d   = res_px_q;
          o_last_d = res_last_q;
          state_d  = gld_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = gld_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= gld_pkg::S_IDLE;
      fin_q        <= gld_pkg::FIN_RUN;
      depth_q      <= 13'd0;
      bitbuf_q     <= 32'd0;
      bitcnt_q     <= 6'd0;
      blk_q        <= 8'd0;
      cw_q         <= 4'd9;
      nfc_q        <= 13'd258;
      prev_q       <= 12'd0;
      prev_valid_q <= 1'b0;
      first_q      <= 8'd0;
      pix_q        <= 32'd0;
      ov_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      fin_q        <= fin_d;
      depth_q      <= depth_d;
      bitbuf_q     <= bitbuf_d;
      bitcnt_q     <= bitcnt_d;
      blk_q        <= blk_d;
      cw_q         <= cw_d;
      nfc_q        <= nfc_d;
      prev_q       <= prev_d;
      prev_valid_q <= prev_valid_d;
      first_q      <= first_d;
      pix_q        <= pix_d;
      ov_q         <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    incode_q   <= incode_d;
    res_st_q   <= res_st_d;
    res_px_q   <= res_px_d;
    res_last_q <= res_last_d;
    o_st_q     <= o_st_d;
    o_px_q     <= o_px_d;
    o_last_q   <= o_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      stack_mem[st_waddr] <= st_wdata;
    end
    stack_rd_q <= stack_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tb_we) begin
      prefix_mem[tb_waddr] <= tb_wprefix;
      suffix_mem[tb_waddr] <= tb_wsuffix;
    end
    prefix_rd_q <= prefix_mem[tb_raddr];
    suffix_rd_q <= suffix_mem[tb_raddr];
  end

endmodule

@@ design/gif_lzw_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gif_lzw_decoder
// gif lzw decoder over the sub-block framed byte stream
// ----------------------------------------------------------------------------
// Each beat carries begin, push byte or pull pixel and returns one result beat.
// Begin and push are handled in the engine, then emitted. A pull that pops a
// stacked pixel reads the stack, pops and emits it; a pull that reads a code
// first fetches it and walks its prefix chain over the registered table reads.
// A 2-deep queue ahead of the engine and a result register behind it let input
// and output stall independently. Registers: 0x0 min_code_size, 0x4 pixel_count.
module gif_lzw_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  gld_in_if.sink      in_i,
  gld_out_if.source   out_o
);

  gld_pkg::cfg_t  cfg_q;
  logic           q_valid, q_ready;
  gld_pkg::item_t q_item;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = paddr[2] ? cfg_q.pixel_count : {28'd0, cfg_q.min_code_size};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_code_size <= 4'd8;
      cfg_q.pixel_count   <= 32'd0;
    end else if (wr_en) begin
      if (paddr[2]) begin
        cfg_q.pixel_count <= pwdata;
      end else begin
        cfg_q.min_code_size <= pwdata[3:0];
      end
    end
  end

  gld_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .func_i      (in_i.func),
    .data_byte_i (in_i.data_byte),
    .q_valid_o   (q_valid),
    .q_ready_i   (q_ready),
    .q_item_o    (q_item)
  );

  gld_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_ready_o     (q_ready),
    .q_item_i      (q_item),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .status_o      (out_o.status),
    .pixel_index_o (out_o.pixel_index),
    .last_pixel_o  (out_o.last_pixel)
  );

endmodule
